[sv/aft_pkg.sv]
// shared types and constants for the address frequency table
// no dependencies; imported by aft_scan_unit and address_frequency_table
`timescale 1ns / 1ps

package aft_pkg;

  // fixed field widths
  localparam int ADDR_W         = 40;
  localparam int COUNT_W        = 32;
  localparam int CMD_W          = 2;
  localparam int ADDR_BYTES_MAX = 5;

  // defaults for the top level parameters
  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int ADDRESS_BYTES_DEF = 5;

  // counts at or above it never win a victim scan; entry 0 is the default
  localparam logic [COUNT_W-1:0] VICTIM_LIMIT    = 32'd10000;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 32'd4;

  // command codes carried on the slave tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD = 2'd0,
    CMD_TAKE   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // what the shared compare unit is doing this cycle
  typedef enum logic [1:0] {
    MODE_VICTIM = 2'd0,
    MODE_TOP    = 2'd1,
    MODE_THRESH = 2'd2
  } scan_mode_e;

  typedef struct packed {
    logic       start;
    scan_mode_e mode;
    logic       beat_valid;
  } scan_ctrl_t;

  typedef struct packed {
    logic hit;
    logic thr_met;
  } scan_status_t;

endpackage

[sv/aft_scan_unit.sv]
// shared compare unit and running accumulators for table scans
// depends on aft_pkg
`timescale 1ns / 1ps

module aft_scan_unit
  import aft_pkg::*;
#(
  parameter int IDX_W = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scan_ctrl_t         ctrl_i,
  input  logic [IDX_W-1:0]   idx_i,
  input  logic [ADDR_W-1:0]  key_i,
  input  logic [ADDR_W-1:0]  rd_addr_i,
  input  logic [COUNT_W-1:0] rd_count_i,
  input  logic               skip_valid_i,
  input  logic [IDX_W-1:0]   skip_idx_i,
  input  logic [COUNT_W-1:0] threshold_i,
  output scan_status_t       status_o,
  output logic [IDX_W-1:0]   best_idx_o,
  output logic [COUNT_W-1:0] best_count_o,
  output logic [ADDR_W-1:0]  best_addr_o,
  output logic [IDX_W-1:0]   hit_idx_o,
  output logic [COUNT_W-1:0] hit_count_o
);

  logic [COUNT_W-1:0] acc_val_q;
  logic [IDX_W-1:0]   acc_idx_q;
  logic [ADDR_W-1:0]  acc_addr_q;
  logic               hit_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [COUNT_W-1:0] hit_count_q;

  logic [COUNT_W-1:0] cmp_a, cmp_b;
  logic               lt;
  logic               skip;
  logic               take_beat;
  logic               match;

  // operand selection for the one magnitude comparator
  always_comb begin
    unique case (ctrl_i.mode)
      MODE_VICTIM: begin
        cmp_a = rd_count_i;
        cmp_b = acc_val_q;
      end
      MODE_TOP: begin
        cmp_a = acc_val_q;
        cmp_b = rd_count_i;
      end
      MODE_THRESH: begin
        cmp_a = acc_val_q;
        cmp_b = threshold_i;
      end
      default: begin
        cmp_a = acc_val_q;
        cmp_b = threshold_i;
      end
    endcase
  end

  assign lt   = cmp_a < cmp_b;
  assign skip = skip_valid_i && (idx_i == skip_idx_i);

  // decide whether this beat replaces the running best
  always_comb begin
    take_beat = 1'b0;
    if (ctrl_i.beat_valid) begin
      if (ctrl_i.mode == MODE_VICTIM) begin
        take_beat = lt && !skip;
      end else if (ctrl_i.mode == MODE_TOP) begin
        // entry zero is the default, so it is always taken
        take_beat = lt || (idx_i == '0);
      end
    end
  end

  assign match = ctrl_i.beat_valid && (ctrl_i.mode == MODE_VICTIM) &&
                 (rd_addr_i == key_i) && !hit_q;

  // hit flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.start) begin
      hit_q <= 1'b0;
    end else if (match) begin
      hit_q <= 1'b1;
    end
  end

  // accumulators and hit payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_val_q  <= (ctrl_i.mode == MODE_VICTIM) ? VICTIM_LIMIT : '0;
      acc_idx_q  <= '0;
      acc_addr_q <= '0;
    end else if (take_beat) begin
      acc_val_q  <= rd_count_i;
      acc_idx_q  <= idx_i;
      acc_addr_q <= rd_addr_i;
    end
    if (match) begin
      hit_idx_q   <= idx_i;
      hit_count_q <= rd_count_i;
    end
  end

  assign status_o.hit     = hit_q;
  assign status_o.thr_met = (ctrl_i.mode == MODE_THRESH) && !lt;
  assign best_idx_o       = acc_idx_q;
  assign best_count_o     = acc_val_q;
  assign best_addr_o      = acc_addr_q;
  assign hit_idx_o        = hit_idx_q;
  assign hit_count_o      = hit_count_q;

endmodule

[sv/address_frequency_table.sv]
// top level of the address frequency table: sequencer, entry memories, config
// depends on aft_pkg and aft_scan_unit
`timescale 1ns / 1ps

// Usage
//   slave stream: tuser[1:0] = cmd (record, take, clear), tdata[39:0] = address.
//   master stream: tdata[39:0] = top address, tdata[71:40] = top count,
//   tuser[0] = found. One result beat for every accepted input beat.
//   the take threshold is written through cfg_we_i / cfg_wdata_i while idle;
//   the user must keep to this, as the block itself does not enforce it.
// Sequence
//   record: one scan for a match and a victim, one write, one scan for the top
//   entry. take and the unused command: one scan. clear: no scan, the entry
//   count is zeroed and the result is an all-zero beat.
//   Each scan reads one entry a cycle from the single read port of the entry
//   memories; one comparator serves every scan step.
//   s_axis_tready is high only between items.
// Reset: entry count zero, no index skipped, threshold 4; entry contents are
//   undefined until written and there is no clearing pass.
// Stall: a finished result waits in the output register; the next item is
//   taken meanwhile and its result waits in the sequencer until the register
//   is free.

module address_frequency_table
  import aft_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int ADDRESS_BYTES = ADDRESS_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // address[39:0]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // top_address[39:0], top_count[71:40]
  output logic        m_axis_tuser,   // found
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int IdxW     = $clog2(TABLE_ENTRIES);
  localparam int UsedW    = $clog2(TABLE_ENTRIES + 1);
  localparam int DropBits = 8 * (ADDR_BYTES_MAX - ADDRESS_BYTES);
  localparam logic [ADDR_W-1:0] KeepMask = {ADDR_W{1'b1}} << DropBits;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MATCH  = 6'b000010,
    S_UPDATE = 6'b000100,
    S_TOP    = 6'b001000,
    S_TAKE   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [ADDR_W-1:0]  key_q, key_d;
  logic [UsedW-1:0]   used_q, used_d;
  logic               lr_valid_q, lr_valid_d;
  logic [IdxW-1:0]    lr_idx_q, lr_idx_d;
  logic [UsedW-1:0]   scan_cnt_q, scan_cnt_d;
  logic               rvalid_q;
  logic [IdxW-1:0]    ridx_q;
  logic [COUNT_W-1:0] thr_q;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic [COUNT_W-1:0] res_count_q, res_count_d;
  logic               res_found_q, res_found_d;
  logic               out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_found_q;
  logic               out_load;

  // entry memories
  logic [ADDR_W-1:0]  addr_mem [TABLE_ENTRIES];
  logic [COUNT_W-1:0] cnt_mem  [TABLE_ENTRIES];
  logic [ADDR_W-1:0]  rd_addr_q;
  logic [COUNT_W-1:0] rd_cnt_q;
  logic               rd_en;
  logic [IdxW-1:0]    rd_idx;
  logic               wr_addr_en, wr_cnt_en;
  logic [IdxW-1:0]    wr_idx;
  logic [COUNT_W-1:0] wr_cnt;

  scan_ctrl_t         scan_ctrl;
  scan_status_t       scan_status;
  logic [IdxW-1:0]    best_idx, hit_idx;
  logic [COUNT_W-1:0] best_count, hit_count;
  logic [ADDR_W-1:0]  best_addr;

  logic accept;
  logic scanning;
  logic scan_done;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign scanning  = (state_q == S_MATCH) || (state_q == S_TOP);
  assign rd_en     = scanning && (scan_cnt_q < used_q);
  assign rd_idx    = scan_cnt_q[IdxW-1:0];
  assign scan_done = (scan_cnt_q == used_q) && !rvalid_q;

  aft_scan_unit #(
    .IDX_W (IdxW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (scan_ctrl),
    .idx_i        (ridx_q),
    .key_i        (key_q),
    .rd_addr_i    (rd_addr_q),
    .rd_count_i   (rd_cnt_q),
    .skip_valid_i (lr_valid_q),
    .skip_idx_i   (lr_idx_q),
    .threshold_i  (thr_q),
    .status_o     (scan_status),
    .best_idx_o   (best_idx),
    .best_count_o (best_count),
    .best_addr_o  (best_addr),
    .hit_idx_o    (hit_idx),
    .hit_count_o  (hit_count)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    used_d      = used_q;
    lr_valid_d  = lr_valid_q;
    lr_idx_d    = lr_idx_q;
    scan_cnt_d  = rd_en ? scan_cnt_q + UsedW'(1) : scan_cnt_q;
    res_addr_d  = res_addr_q;
    res_count_d = res_count_q;
    res_found_d = res_found_q;
    out_load    = 1'b0;
    wr_addr_en  = 1'b0;
    wr_cnt_en   = 1'b0;
    wr_idx      = best_idx;
    wr_cnt      = '0;
    scan_ctrl.start      = 1'b0;
    scan_ctrl.mode       = MODE_THRESH;
    scan_ctrl.beat_valid = rvalid_q;

    unique case (state_q)
      S_IDLE: begin
        scan_ctrl.mode  = (s_axis_tuser == CMD_RECORD) ? MODE_VICTIM : MODE_TOP;
        scan_ctrl.start = accept;
        if (accept) begin
          cmd_d      = s_axis_tuser;
          key_d      = s_axis_tdata & KeepMask;
          scan_cnt_d = '0;
          if (s_axis_tuser == CMD_CLEAR) begin
            used_d      = '0;
            res_addr_d  = '0;
            res_count_d = '0;
            res_found_d = 1'b0;
            state_d     = S_DONE;
          end else if (s_axis_tuser == CMD_RECORD) begin
            state_d = S_MATCH;
          end else begin
            state_d = S_TOP;
          end
        end
      end
      S_MATCH: begin
        scan_ctrl.mode = MODE_VICTIM;
        if (scan_done) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // hit, append or replace, then rescan for the top entry
        scan_ctrl.mode  = MODE_TOP;
        scan_ctrl.start = 1'b1;
        scan_cnt_d      = '0;
        state_d         = S_TOP;
        wr_cnt_en       = 1'b1;
        if (scan_status.hit) begin
          wr_idx = hit_idx;
          wr_cnt = (&hit_count) ? hit_count : hit_count + COUNT_W'(1);
        end else if (used_q < UsedW'(TABLE_ENTRIES)) begin
          wr_idx     = used_q[IdxW-1:0];
          wr_addr_en = 1'b1;
          wr_cnt     = COUNT_W'(1);
          used_d     = used_q + UsedW'(1);
        end else begin
          wr_idx     = best_idx;
          wr_addr_en = 1'b1;
          wr_cnt     = COUNT_W'(1);
          lr_valid_d = 1'b1;
          lr_idx_d   = best_idx;
        end
      end
      S_TOP: begin
        scan_ctrl.mode = MODE_TOP;
        if (scan_done) begin
          state_d = S_TAKE;
        end
      end
      S_TAKE: begin
        // threshold check on the shared comparator, zero the count on success
        scan_ctrl.mode = MODE_THRESH;
        res_addr_d     = best_addr;
        res_count_d    = best_count;
        res_found_d    = (cmd_q == CMD_TAKE) && scan_status.thr_met;
        if ((cmd_q == CMD_TAKE) && scan_status.thr_met) begin
          wr_cnt_en = 1'b1;
          wr_idx    = best_idx;
          wr_cnt    = '0;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      lr_valid_q  <= 1'b0;
      scan_cnt_q  <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= THRESHOLD_RESET;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      lr_valid_q  <= lr_valid_d;
      scan_cnt_q  <= scan_cnt_d;
      rvalid_q    <= rd_en;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    lr_idx_q    <= lr_idx_d;
    ridx_q      <= rd_idx;
    res_addr_q  <= res_addr_d;
    res_count_q <= res_count_d;
    res_found_q <= res_found_d;
    if (out_load) begin
      out_addr_q  <= res_addr_q;
      out_count_q <= res_count_q;
      out_found_q <= res_found_q;
    end
  end

  // entry memories, one read and one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_addr_q <= addr_mem[rd_idx];
      rd_cnt_q  <= cnt_mem[rd_idx];
    end
    if (wr_addr_en) begin
      addr_mem[wr_idx] <= key_q;
    end
    if (wr_cnt_en) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_count_q, out_addr_q};
  assign m_axis_tuser  = out_found_q;

`ifndef SYNTHESIS
  // entry count never exceeds the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  // a clear beat empties the table on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tuser == CMD_CLEAR)) |=> (used_q == '0))
    else $error("clear did not reset entry count");

  // scan reads never run past the used entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scanning |-> (scan_cnt_q <= used_q))
    else $error("scan index past used entries");
`endif

endmodule

[sim/tb_address_frequency_table.sv]
// testbench for address_frequency_table: directed and random record/take/clear traffic
// predicts each result beat with an in-bench table model; depends on aft_pkg and the dut
`timescale 1ns / 1ps

module tb_address_frequency_table;
  import aft_pkg::*;

  localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int ADDRESS_BYTES = ADDRESS_BYTES_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_KEEP = {ADDR_W{1'b1}} << (8 * (ADDR_BYTES_MAX - ADDRESS_BYTES));
  localparam int NO_VICTIM = 255;
  localparam int POOL_MAX = 300;
  localparam int IDLE_PCT = 7;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] count;
    logic               found;
  } top_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  // table mirror
  logic [ADDR_W-1:0]  tbl_addr  [TABLE_ENTRIES];
  logic [COUNT_W-1:0] tbl_count [TABLE_ENTRIES];
  int                 tbl_used;
  int                 tbl_last_victim;
  logic [COUNT_W-1:0] threshold;

  top_report_t        pending_tops[$];
  logic [ADDR_W-1:0]  addr_pool [POOL_MAX];
  int                 error_count;
  logic               no_idle;

  address_frequency_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDRESS_BYTES (ADDRESS_BYTES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit, several times the slowest legal run
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  // apply one command to the mirror and return the top entry it reports
  function automatic top_report_t table_step(input logic [CMD_W-1:0] cmd,
                                             input logic [ADDR_W-1:0] address);
    logic [ADDR_W-1:0]  key;
    logic               hit;
    int                 slot;
    int                 top_idx;
    logic [COUNT_W-1:0] lowest;
    logic [COUNT_W-1:0] best;
    top_report_t        rep;
    key = address & ADDR_KEEP;
    rep = '0;
    if (cmd == CMD_CLEAR) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tbl_addr[i]  = '0;
        tbl_count[i] = '0;
      end
      tbl_used = 0;
      return rep;
    end
    // lookup, then append or evict on a miss
    if (cmd == CMD_RECORD) begin
      hit = 1'b0;
      for (int i = 0; i < tbl_used; i++) begin
        if (!hit && tbl_addr[i] == key) begin
          hit = 1'b1;
          if (tbl_count[i] != '1) tbl_count[i] = tbl_count[i] + 1'b1;
        end
      end
      if (!hit) begin
        if (tbl_used >= TABLE_ENTRIES) begin
          lowest = VICTIM_LIMIT;
          slot   = 0;
          for (int i = 0; i < tbl_used; i++) begin
            if (i != tbl_last_victim && tbl_count[i] < lowest) begin
              lowest = tbl_count[i];
              slot   = i;
            end
          end
          tbl_last_victim = slot;
        end else begin
          slot     = tbl_used;
          tbl_used = tbl_used + 1;
        end
        tbl_addr[slot]  = key;
        tbl_count[slot] = 1;
      end
    end
    // highest count, first index wins
    best    = '0;
    top_idx = 0;
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_count[i] > best) begin
        best    = tbl_count[i];
        top_idx = i;
      end
    end
    rep.address = tbl_addr[top_idx];
    rep.count   = tbl_count[top_idx];
    if (cmd == CMD_TAKE && tbl_count[top_idx] >= threshold) begin
      tbl_count[top_idx] = '0;
      rep.found          = 1'b1;
    end
    return rep;
  endfunction

  // one input beat, with an occasional gap in front
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] address);
    int gap;
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= address;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pending_tops.push_back(table_step(cmd, address));
  endtask

  // hold the sender until every outstanding result beat is back
  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    while (pending_tops.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [COUNT_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    threshold = value;
    @(posedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] random_address();
    logic [ADDR_W-1:0] a;
    a = ADDR_W'({$urandom(), $urandom()});
    return a;
  endfunction

  task automatic fill_pool(input int size);
    for (int i = 0; i < size; i++) addr_pool[i] = random_address();
  endtask

  // random commands, records drawn mostly from a pool so that hits recur
  task automatic test_random_mix(input int items, input int pool_size,
                                 input int take_pct, input int clear_pct);
    int                r;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] a;
    fill_pool(pool_size);
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      if (r < clear_pct) cmd = CMD_CLEAR;
      else if (r < clear_pct + 2) cmd = CMD_UNUSED;
      else if (r < clear_pct + 2 + take_pct) cmd = CMD_TAKE;
      else cmd = CMD_RECORD;
      r = $urandom_range(0, 99);
      if (cmd != CMD_RECORD || r < 5) a = random_address();
      else if (r < 12) a = addr_pool[$urandom_range(0, pool_size - 1)] ^
                           (40'd1 << $urandom_range(0, ADDR_W - 1));
      else a = addr_pool[$urandom_range(0, pool_size - 1)];
      if ($urandom_range(0, 99) == 0) drain_results();
      send_beat(cmd, a);
    end
  endtask

  // first records, repeated hits and the extremes of the address
  task automatic test_record_hits;
    send_beat(CMD_RECORD, 40'h00_0000_0000);
    send_beat(CMD_RECORD, 40'hFF_FFFF_FFFF);
    send_beat(CMD_RECORD, 40'hFF_FFFF_FFFF);
    send_beat(CMD_RECORD, 40'hA5_A5A5_A5A5);
    send_beat(CMD_RECORD, 40'h5A_5A5A_5A5A);
    send_beat(CMD_UNUSED, 40'h12_3456_789A);
  endtask

  // take below and at the reset threshold, then first index wins on a tie
  task automatic test_take_threshold;
    send_beat(CMD_TAKE, 40'h00_0000_0000);
    send_beat(CMD_RECORD, 40'hFF_FFFF_FFFF);
    send_beat(CMD_RECORD, 40'hFF_FFFF_FFFF);
    send_beat(CMD_TAKE, 40'hFF_FFFF_FFFF);
    send_beat(CMD_TAKE, 40'h00_0000_0000);
  endtask

  task automatic test_threshold_extremes;
    write_threshold(32'h0000_0000);
    send_beat(CMD_TAKE, 40'h00_0000_0000);
    send_beat(CMD_TAKE, 40'h00_0000_0000);
    write_threshold(32'hFFFF_FFFF);
    send_beat(CMD_TAKE, 40'hFF_FFFF_FFFF);
  endtask

  // clear, then an empty table, then refill
  task automatic test_clear_table;
    send_beat(CMD_CLEAR, 40'hFF_FFFF_FFFF);
    send_beat(CMD_TAKE, 40'h00_0000_0000);
    send_beat(CMD_UNUSED, 40'hFF_FFFF_FFFF);
    send_beat(CMD_RECORD, 40'hC3_0000_003C);
    send_beat(CMD_TAKE, 40'h00_0000_0000);
  endtask

  task automatic test_hot_addresses;
    write_threshold(THRESHOLD_RESET);
    test_random_mix(160, 24, 12, 2);
  endtask

  // enough distinct addresses to fill the table and force evictions
  task automatic test_table_eviction;
    write_threshold($urandom_range(1, 8));
    no_idle = 1'b1;
    send_beat(CMD_CLEAR, random_address());
    test_random_mix(260, POOL_MAX, 6, 0);
    drain_results();
    no_idle = 1'b0;
  endtask

  task automatic test_threshold_sweep;
    write_threshold(32'hFFFF_FFFF);
    test_random_mix(70, 16, 20, 3);
    write_threshold(32'h0000_0000);
    test_random_mix(70, 16, 20, 5);
    write_threshold($urandom_range(0, 1) ? $urandom() : $urandom_range(1, 12));
    test_random_mix(80, 20, 15, 3);
  endtask

  // result beat checker and receiver back-pressure
  initial begin
    top_report_t want;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_tops.size() == 0) begin
          $error("result beat with none expected: top_addr %h", m_axis_tdata[39:0]);
          error_count++;
        end else begin
          want = pending_tops.pop_front();
          if (m_axis_tdata[39:0] !== want.address) begin
            $error("top_addr: expected %h, got %h", want.address, m_axis_tdata[39:0]);
            error_count++;
          end
          if (m_axis_tdata[71:40] !== want.count) begin
            $error("top_count: expected %0d, got %0d", want.count, m_axis_tdata[71:40]);
            error_count++;
          end
          if (m_axis_tuser !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, m_axis_tuser);
            error_count++;
          end
        end
      end
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // stimulus
  initial begin
    error_count     = 0;
    no_idle         = 1'b0;
    threshold       = THRESHOLD_RESET;
    tbl_used        = 0;
    tbl_last_victim = NO_VICTIM;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_addr[i]  = '0;
      tbl_count[i] = '0;
    end
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_record_hits();
    test_take_threshold();
    test_threshold_extremes();
    test_clear_table();
    test_hot_addresses();
    test_table_eviction();
    test_threshold_sweep();

    drain_results();
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
